### sv/sobel_pkg.sv
// ----------------------------------------------------------------------------
// Sobel edge package
// Shared types and constants of the inverted Sobel edge magnitude unit.
// ----------------------------------------------------------------------------
package sobel_pkg;

   localparam int MaxWidth   = 1024;
   localparam int MaxHeight  = 4096;
   localparam int ColBits    = $clog2(MaxWidth);
   localparam int RowBits    = $clog2(MaxHeight);
   localparam int WidthBits  = ColBits + 1;
   localparam int HeightBits = RowBits + 1;
   localparam int JobDepth   = 4;
   localparam int JobPtrBits = $clog2(JobDepth);

   typedef enum logic {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } req_type;

   typedef struct packed {
      logic [ColBits-1:0] col;
      logic [RowBits-1:0] row;
      logic [7:0]         level;
      logic               run_last;
      logic               frame_done;
   } rsp_type;

   typedef struct packed {
      logic [2:0][2:0][7:0] win;
      logic [ColBits-1:0]   col;
      logic [RowBits-1:0]   row;
      logic [3:0]           emit;
      logic                 inner;
   } job_type;

   typedef struct packed {
      logic empty;
      logic room;
   } queue_status_type;

   typedef enum logic {
      FRONT_IDLE,
      FRONT_LOAD
   } front_state_type;

   typedef enum logic [2:0] {
      BACK_IDLE,
      BACK_GRAD,
      BACK_SUM,
      BACK_ROOT,
      BACK_EMIT
   } back_state_type;

endpackage

### sv/sobel_edge_magnitude_inverted_unit.sv
// ----------------------------------------------------------------------------
// Inverted Sobel edge magnitude unit
// Steps: the front end takes a pixel in FRONT_IDLE and forms its job in
// FRONT_LOAD, and takes no new pixel while it loads one. The back end pops a
// job and, for an inner pixel, forms the gradients, sums their squares and runs
// the eight-step root search; it then emits each result slot up to the last
// one, holding while a waiting result has not been taken.
// Reset clears counters, window, queues and control state; line stores keep.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_inverted_unit import sobel_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  req_type     req_data,
   output logic        empty,
   input  logic        pop,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [12:0] csr_data
);

   queue_status_type queue_status;
   job_type          job_in_data, job_head;
   logic             job_push, job_pop;

   assign csr_ready = 1'b1;

   sobel_front u_front (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .full         (full),
      .req_data     (req_data),
      .csr_valid    (csr_valid),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .queue_status (queue_status),
      .job_push     (job_push),
      .job_data     (job_in_data)
   );

   sobel_job_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_in_data),
      .pop       (job_pop),
      .head_data (job_head),
      .status    (queue_status)
   );

   sobel_back u_back (
      .clock        (clock),
      .reset        (reset),
      .queue_status (queue_status),
      .job_data     (job_head),
      .job_pop      (job_pop),
      .empty        (empty),
      .pop          (pop),
      .rsp_data     (rsp_data)
   );

endmodule

### sv/sobel_front.sv
// ----------------------------------------------------------------------------
// Sobel front end
// Converts pixels to gray, keeps the line stores and window, and forms jobs.
// ----------------------------------------------------------------------------
module sobel_front import sobel_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  req_type           req_data,
   input  logic              csr_valid,
   input  logic              csr_index,
   input  logic [12:0]       csr_data,
   input  queue_status_type  queue_status,
   output logic              job_push,
   output job_type           job_data
);

   front_state_type       state_ff, state_in;
   logic [WidthBits-1:0]  frame_width_ff, frame_width_in;
   logic [HeightBits-1:0] frame_height_ff, frame_height_in;
   logic [ColBits-1:0]    col_ff, col_in;
   logic [RowBits-1:0]    row_ff, row_in;
   logic [2:0][2:0][7:0]  win_ff, win_in;
   logic [7:0]            gray_ff, gray_in;
   logic [7:0]            upper_rd_ff, middle_rd_ff;
   logic [7:0]            upper_mem [MaxWidth];
   logic [7:0]            middle_mem [MaxWidth];
   logic [WidthBits-1:0]  w_eff;
   logic [HeightBits-1:0] h_eff;
   logic [9:0]            sum;
   logic [19:0]           scaled;
   logic                  accept, last_col, last_row, inner;

   assign full   = (state_ff != FRONT_IDLE) || !queue_status.room;
   assign accept = push && !full;

   always_comb begin
      sum    = {2'b00, req_data.red} + {2'b00, req_data.green} + {2'b00, req_data.blue};
      scaled = 20'(sum) * 20'd683;
      gray_in = scaled[18:11];
   end

   always_comb begin
      if (frame_width_ff == '0) begin
         w_eff = WidthBits'(1);
      end else if (frame_width_ff > WidthBits'(MaxWidth)) begin
         w_eff = WidthBits'(MaxWidth);
      end else begin
         w_eff = frame_width_ff;
      end
      if (frame_height_ff == '0) begin
         h_eff = HeightBits'(1);
      end else if (frame_height_ff > HeightBits'(MaxHeight)) begin
         h_eff = HeightBits'(MaxHeight);
      end else begin
         h_eff = frame_height_ff;
      end
      last_col = {1'b0, col_ff} >= w_eff - WidthBits'(1);
      last_row = {1'b0, row_ff} >= h_eff - HeightBits'(1);
      inner    = (col_ff >= ColBits'(2)) && (row_ff >= RowBits'(2)) &&
                 ({1'b0, col_ff} <= w_eff - WidthBits'(1)) &&
                 ({1'b0, row_ff} <= h_eff - HeightBits'(1));
   end

   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_FRAME_WIDTH:  frame_width_in  = csr_data[WidthBits-1:0];
            CSR_FRAME_HEIGHT: frame_height_in = csr_data[HeightBits-1:0];
            default:          frame_width_in  = frame_width_ff;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      win_in   = win_ff;
      job_push = 1'b0;
      for (int i = 0; i < 3; i++) begin
         win_in[i][0] = win_ff[i][1];
         win_in[i][1] = win_ff[i][2];
      end
      win_in[0][2] = upper_rd_ff;
      win_in[1][2] = middle_rd_ff;
      win_in[2][2] = gray_ff;
      job_data.win   = win_in;
      job_data.col   = col_ff;
      job_data.row   = row_ff;
      job_data.inner = inner;
      job_data.emit[0] = (row_ff != '0) && (col_ff != '0);
      job_data.emit[1] = (row_ff != '0) && last_col;
      job_data.emit[2] = last_row && (col_ff != '0);
      job_data.emit[3] = last_row && last_col;
      unique case (state_ff)
         FRONT_IDLE: begin
            win_in = win_ff;
            if (accept) begin
               state_in = FRONT_LOAD;
            end
         end
         FRONT_LOAD: begin
            job_push = 1'b1;
            state_in = FRONT_IDLE;
            if (last_col) begin
               col_in = '0;
               row_in = last_row ? '0 : row_ff + RowBits'(1);
            end else begin
               col_in = col_ff + ColBits'(1);
            end
         end
         default: state_in = FRONT_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= FRONT_IDLE;
         frame_width_ff  <= WidthBits'(MaxWidth);
         frame_height_ff <= HeightBits'(768);
         col_ff          <= '0;
         row_ff          <= '0;
         win_ff          <= '0;
      end else begin
         state_ff        <= state_in;
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
         col_ff          <= col_in;
         row_ff          <= row_in;
         win_ff          <= win_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         gray_ff      <= gray_in;
         upper_rd_ff  <= upper_mem[col_ff];
         middle_rd_ff <= middle_mem[col_ff];
      end
      if (state_ff == FRONT_LOAD) begin
         upper_mem[col_ff]  <= middle_rd_ff;
         middle_mem[col_ff] <= gray_ff;
      end
   end

endmodule

### sv/sobel_job_queue.sv
// ----------------------------------------------------------------------------
// Sobel job queue
// Short first-in first-out store of jobs between the front and back ends.
// ----------------------------------------------------------------------------
module sobel_job_queue import sobel_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  job_type          push_data,
   input  logic             pop,
   output job_type          head_data,
   output queue_status_type status
);

   job_type               entry_ff [JobDepth];
   logic [JobPtrBits-1:0] wr_ptr_ff, wr_ptr_in;
   logic [JobPtrBits-1:0] rd_ptr_ff, rd_ptr_in;
   logic [JobPtrBits:0]   count_ff, count_in;

   assign head_data    = entry_ff[rd_ptr_ff];
   assign status.empty = (count_ff == '0);
   assign status.room  = (count_ff != (JobPtrBits+1)'(JobDepth));

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + JobPtrBits'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + JobPtrBits'(1) : rd_ptr_ff;
      count_in  = count_ff + (JobPtrBits+1)'(push) - (JobPtrBits+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### sv/sobel_back.sv
// ----------------------------------------------------------------------------
// Sobel back end
// Computes the inverted edge level of an inner job, passes the other pixels'
// gray levels through, and emits its results one at a time.
module sobel_back import sobel_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  queue_status_type queue_status,
   input  job_type          job_data,
   output logic             job_pop,
   output logic             empty,
   input  logic             pop,
   output rsp_type          rsp_data
);

   back_state_type      state_ff, state_in;
   job_type             job_ff, job_in;
   logic signed [11:0]  gx_ff, gx_in, gy_ff, gy_in;
   logic [23:0]         s4_ff, s4_in;
   logic [7:0]          root_ff, root_in;
   logic [2:0]          step_ff, step_in;
   logic [1:0]          slot_ff, slot_in;
   logic                out_valid_ff, out_valid_in;
   rsp_type             out_ff, out_in;
   logic [7:0]          trial;
   logic [15:0]         trial_sq;
   logic [19:0]         trial_9;
   logic [21:0]         sq_x, sq_y;
   logic [3:0]          later;
   logic                out_free, slot_on, slot_last;

   assign empty    = !out_valid_ff;
   assign rsp_data = out_ff;
   assign out_free = !out_valid_ff || pop;

   always_comb begin
      trial    = root_ff | (8'd1 << step_ff);
      trial_sq = 16'(trial) * 16'(trial);
      trial_9  = {trial_sq, 3'b000} + 20'(trial_sq);
      sq_x     = 22'(gx_ff * gx_ff);
      sq_y     = 22'(gy_ff * gy_ff);
      case (slot_ff)
         2'd0:    later = 4'b1110;
         2'd1:    later = 4'b1100;
         2'd2:    later = 4'b1000;
         default: later = 4'b0000;
      endcase
      slot_on   = job_ff.emit[slot_ff];
      slot_last = !(|(job_ff.emit & later));
   end

   always_comb begin
      gx_in = 12'(job_ff.win[0][2]) + 12'({job_ff.win[1][2], 1'b0}) + 12'(job_ff.win[2][2])
            - 12'(job_ff.win[0][0]) - 12'({job_ff.win[1][0], 1'b0}) - 12'(job_ff.win[2][0]);
      gy_in = 12'(job_ff.win[2][0]) + 12'({job_ff.win[2][1], 1'b0}) + 12'(job_ff.win[2][2])
            - 12'(job_ff.win[0][0]) - 12'({job_ff.win[0][1], 1'b0}) - 12'(job_ff.win[0][2]);
      s4_in = {sq_x + sq_y, 2'b00};
   end

   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      root_in      = root_ff;
      step_in      = step_ff;
      slot_in      = slot_ff;
      job_pop      = 1'b0;
      out_valid_in = out_valid_ff && !pop;
      out_in       = out_ff;
      unique case (slot_ff)
         2'd0: begin
            out_in.col   = job_ff.col - ColBits'(1);
            out_in.row   = job_ff.row - RowBits'(1);
            out_in.level = job_ff.inner ? 8'd255 - root_ff : job_ff.win[1][1];
         end
         2'd1: begin
            out_in.col   = job_ff.col;
            out_in.row   = job_ff.row - RowBits'(1);
            out_in.level = job_ff.win[1][2];
         end
         2'd2: begin
            out_in.col   = job_ff.col - ColBits'(1);
            out_in.row   = job_ff.row;
            out_in.level = job_ff.win[2][1];
         end
         default: begin
            out_in.col   = job_ff.col;
            out_in.row   = job_ff.row;
            out_in.level = job_ff.win[2][2];
         end
      endcase
      out_in.run_last   = slot_last;
      out_in.frame_done = (slot_ff == 2'd3);
      unique case (state_ff)
         BACK_IDLE: begin
            if (!queue_status.empty) begin
               job_pop = 1'b1;
               job_in  = job_data;
               slot_in = '0;
               root_in = '0;
               step_in = 3'd7;
               state_in = (job_data.emit[0] && job_data.inner) ? BACK_GRAD : BACK_EMIT;
            end
         end
         BACK_GRAD: state_in = BACK_SUM;
         BACK_SUM:  state_in = BACK_ROOT;
         BACK_ROOT: begin
            if (trial_9 <= 20'(s4_ff) && s4_ff[23:20] == '0 || {4'b0, trial_9} <= s4_ff) begin
               root_in = trial;
            end
            step_in = step_ff - 3'd1;
            if (step_ff == '0) begin
               state_in = BACK_EMIT;
            end
         end
         BACK_EMIT: begin
            if (!slot_on) begin
               slot_in = slot_ff + 2'd1;
               if (slot_last) begin
                  state_in = BACK_IDLE;
               end
            end else if (out_free) begin
               out_valid_in = 1'b1;
               slot_in      = slot_ff + 2'd1;
               if (slot_last) begin
                  state_in = BACK_IDLE;
               end
            end
         end
         default: state_in = BACK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff  <= job_in;
      root_ff <= root_in;
      step_ff <= step_in;
      slot_ff <= slot_in;
      gx_ff   <= gx_in;
      gy_ff   <= gy_in;
      s4_ff   <= s4_in;
      if (state_ff == BACK_EMIT && slot_on && out_free) begin
         out_ff <= out_in;
      end
   end

endmodule

### sv/sobel_checker.sv
// ----------------------------------------------------------------------------
// Sobel port checker
// Checks port behavior of the inverted Sobel edge magnitude unit over time.
// ----------------------------------------------------------------------------
module sobel_checker import sobel_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    push,
   input logic    full,
   input logic    empty,
   input logic    pop,
   input rsp_type rsp_data,
   input logic    csr_ready
);

   a_reset_empty: assert property (@(posedge clock) reset |=> empty)
      else $error("Result queue not empty after reset.");

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_data.frame_done |-> rsp_data.run_last)
      else $error("Frame end result is not the last of its request.");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      !empty && !pop |=> !empty && $stable(rsp_data))
      else $error("Waiting result changed before it was taken.");

   a_csr_ready: assert property (@(posedge clock) disable iff (reset) csr_ready)
      else $error("Configuration port not ready.");

   a_full_after_accept: assert property (@(posedge clock) disable iff (reset)
      push && !full |=> full)
      else $error("Input not full in the cycle after a request was taken.");

endmodule

bind sobel_edge_magnitude_inverted_unit sobel_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .push      (push),
   .full      (full),
   .empty     (empty),
   .pop       (pop),
   .rsp_data  (rsp_data),
   .csr_ready (csr_ready)
);
